// File: rtl/core/drfbs_pkg.sv
// Package: shared widths, command codes and bin constants for the depth range segmenter.
`timescale 1ns / 1ps
package drfbs_pkg;

    localparam int DEPTH_BITS = 16;
    localparam int NUM_BINS   = 4;
    localparam int BIN_BITS   = $clog2(NUM_BINS);
    localparam int SCALE_BITS = DEPTH_BITS + BIN_BITS;

    localparam logic CMD_MEASURE  = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    typedef logic [DEPTH_BITS-1:0] depth_t;
    typedef logic [SCALE_BITS-1:0] scaled_t;
    typedef logic [BIN_BITS-1:0]   bin_t;

endpackage

// File: rtl/core/depth_range_four_bin_segmenter_core.sv
// Top level: min/max range tracker and four-bin equal-width depth classifier.
//
// Input channel (in_valid / in_stall) carries one depth sample per beat with a
// command: measure (cmd 0) or classify (cmd 1). Measure beats update a running
// minimum and maximum of nonzero depths; frame_first restarts both. Measure
// beats give no output. Classify beats give one output beat (bin_index, in_bin,
// depth_out) on the out_valid / out_stall channel.
// A classify beat passes through the input register and then the output register.
// Throughput: one beat per cycle while the output is not stalled, set by a single
// input register feeding one compare stage into the output register.
// The input register doubles as a skid slot: while the output is stalled, one
// more beat is still taken, and measure beats keep draining past a stall.
// The range reaches the classify logic only through the input register, so a
// classify beat sees every measure beat accepted before it.
// Reset clears both valid flags, sets the minimum to all ones and the maximum
// to zero, so a classify pass without a measure pass puts every sample in no bin.
// A stalled output beat holds its value until taken.
`timescale 1ns / 1ps
module depth_range_four_bin_segmenter_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     cmd,
    input  logic                     frame_first,
    input  drfbs_pkg::depth_t        depth_in,
    output logic                     out_valid,
    input  logic                     out_stall,
    output drfbs_pkg::bin_t          bin_index,
    output logic                     in_bin,
    output drfbs_pkg::depth_t        depth_out
);
    import drfbs_pkg::*;

    logic   s1_valid_reg, s1_valid_next;
    logic   s1_cmd_reg;
    logic   s1_first_reg;
    depth_t s1_depth_reg;

    depth_t range_low_reg, range_low_next;
    depth_t range_high_reg, range_high_next;

    logic   out_valid_reg, out_valid_next;
    bin_t   bin_reg;
    logic   hit_reg;
    depth_t depth_out_reg;

    logic    out_free;
    logic    s1_leave;
    logic    in_take;
    depth_t  cur_low;
    depth_t  cur_high;
    depth_t  span;
    scaled_t span_x1;
    scaled_t span_x2;
    scaled_t span_x3;
    scaled_t scaled;
    logic    hit;
    bin_t    bin;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_leave = s1_valid_reg && ((s1_cmd_reg == CMD_MEASURE) || out_free);
    assign in_stall = s1_valid_reg && !s1_leave;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next = in_take || (s1_valid_reg && !s1_leave);

    // range update from the measure beat in the input register
    always_comb
    begin
        cur_low  = range_low_reg;
        cur_high = range_high_reg;
        if (s1_first_reg)
        begin
            cur_low  = '1;
            cur_high = '0;
        end
        range_low_next  = cur_low;
        range_high_next = cur_high;
        if (s1_depth_reg != '0)
        begin
            if (s1_depth_reg > cur_high)
                range_high_next = s1_depth_reg;
            if (s1_depth_reg < cur_low)
                range_low_next = s1_depth_reg;
        end
    end

    // bin k holds 4*(d-low) in [k*span, (k+1)*span)
    always_comb
    begin
        span    = range_high_reg - range_low_reg;
        span_x1 = SCALE_BITS'(span);
        span_x2 = span_x1 << 1;
        span_x3 = span_x1 + span_x2;
        scaled  = SCALE_BITS'(s1_depth_reg - range_low_reg) << BIN_BITS;
        hit     = (s1_depth_reg != '0) && (range_high_reg > range_low_reg)
                  && (s1_depth_reg >= range_low_reg) && (s1_depth_reg < range_high_reg);
        bin     = '0;
        if (hit)
        begin
            if (scaled >= span_x3)
                bin = BIN_BITS'(3);
            else if (scaled >= span_x2)
                bin = BIN_BITS'(2);
            else if (scaled >= span_x1)
                bin = BIN_BITS'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = s1_leave && (s1_cmd_reg == CMD_CLASSIFY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            range_low_reg  <= '1;
            range_high_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_leave && (s1_cmd_reg == CMD_MEASURE))
            begin
                range_low_reg  <= range_low_next;
                range_high_reg <= range_high_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg   <= cmd;
            s1_first_reg <= frame_first;
            s1_depth_reg <= depth_in;
        end
        if (out_free && s1_leave && (s1_cmd_reg == CMD_CLASSIFY))
        begin
            bin_reg       <= bin;
            hit_reg       <= hit;
            depth_out_reg <= s1_depth_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign bin_index = bin_reg;
    assign in_bin    = hit_reg;
    assign depth_out = depth_out_reg;

endmodule

// File: bench/tb_depth_range_four_bin_segmenter_core.sv
// Testbench: random and directed depth frames against a min/max four-bin classifier predictor.
`timescale 1ns / 1ps

typedef struct {
    drfbs_pkg::bin_t   bin;
    logic              hit;
    drfbs_pkg::depth_t depth;
} bin_result_t;

class range_bin_tracker;
    drfbs_pkg::depth_t range_low;
    drfbs_pkg::depth_t range_high;
    bin_result_t       pending_bins[$];
    int                errors;

    function new();
        range_low  = '1;
        range_high = '0;
        errors     = 0;
    endfunction

    function int pending();
        return pending_bins.size();
    endfunction

    function void flag(string what);
        errors++;
        if (errors <= 10)
            $display("mismatch: %s", what);
    endfunction

    function void note_input(logic c, logic f, drfbs_pkg::depth_t d);
        bin_result_t e;
        logic [19:0] span;
        logic [19:0] scaled;
        if (c == drfbs_pkg::CMD_MEASURE)
        begin
            if (f)
            begin
                range_low  = '1;
                range_high = '0;
            end
            if (d != 0)
            begin
                if (d > range_high)
                    range_high = d;
                if (d < range_low)
                    range_low = d;
            end
        end
        else
        begin
            e.bin   = '0;
            e.hit   = 1'b0;
            e.depth = d;
            if (d != 0 && range_high > range_low && d >= range_low && d < range_high)
            begin
                span   = 20'(range_high - range_low);
                scaled = 20'(drfbs_pkg::NUM_BINS) * 20'(d - range_low);
                for (int k = 0; k < drfbs_pkg::NUM_BINS; k++)
                begin
                    if (!e.hit && scaled >= k * span && scaled < (k + 1) * span)
                    begin
                        e.bin = drfbs_pkg::bin_t'(k);
                        e.hit = 1'b1;
                    end
                end
            end
            pending_bins = {pending_bins, e};
        end
    endfunction

    function void check_result(drfbs_pkg::bin_t b, logic h, drfbs_pkg::depth_t d);
        bin_result_t e;
        if (pending_bins.size() == 0)
        begin
            flag($sformatf("unexpected beat bin=%0d in_bin=%0d depth=%0d", b, h, d));
            return;
        end
        e = pending_bins.pop_front();
        if (b !== e.bin || h !== e.hit || d !== e.depth)
            flag($sformatf({"depth %0d: expected bin=%0d in_bin=%0d depth=%0d,",
                            " got bin=%0d in_bin=%0d depth=%0d"},
                           e.depth, e.bin, e.hit, e.depth, b, h, d));
    endfunction
endclass

module tb_depth_range_four_bin_segmenter_core;
    import drfbs_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 1400;

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   in_valid    = 1'b0;
    logic   in_stall;
    logic   cmd         = CMD_MEASURE;
    logic   frame_first = 1'b0;
    depth_t depth_in    = '0;
    logic   out_valid;
    logic   out_stall   = 1'b0;
    bin_t   bin_index;
    logic   in_bin;
    depth_t depth_out;

    range_bin_tracker sb = new();

    int       burst_left = 0;
    bit       steady     = 0;
    int       items      = 0;
    int       cycles     = 0;
    int       stall_mode = 0;
    bit [7:0] phase      = '0;

    depth_range_four_bin_segmenter_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .frame_first (frame_first),
        .depth_in    (depth_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bin_index   (bin_index),
        .in_bin      (in_bin),
        .depth_out   (depth_out)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: check taken beats, stall on a mode that is picked anew at random whenever phase[5:0] wraps to zero
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_result(bin_index, in_bin, depth_out);
        phase++;
        if (phase[5:0] == 0)
            stall_mode = $urandom_range(3);
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(1));
            2:       out_stall <= ($urandom_range(3) != 0);
            default: out_stall <= (phase[4:3] == 2'b00);
        endcase
    end

    task automatic send_beat(input logic c, input logic f, input depth_t d);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd         <= c;
        frame_first <= f;
        depth_in    <= d;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.note_input(c, f, d);
        items++;
    endtask

    function automatic depth_t pick_depth(int base, int spread);
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 12)
            return '1;
        if (r < 18)
            return depth_t'($urandom);
        v = base + $urandom_range(spread + 4) - 2;
        if (v < 1)
            v = 1;
        if (v > 65535)
            v = 65535;
        return depth_t'(v);
    endfunction

    // one frame: measure pass then classify pass, occasionally scrambled
    task automatic run_frame();
        int  base;
        int  spread;
        int  r;
        int  n_meas;
        int  n_cls;
        bit  noise;
        logic c;
        logic f;
        r = $urandom_range(9);
        if (r < 5)
            spread = $urandom_range(20);
        else if (r < 8)
            spread = $urandom_range(2000);
        else
            spread = $urandom_range(65535);
        base = $urandom_range(65535);
        if (base + spread > 65535)
            base = 65535 - spread;
        noise  = ($urandom_range(9) == 0);
        steady = ($urandom_range(4) == 0);
        n_meas = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 12);
        n_cls  = $urandom_range(1, 16);
        for (int i = 0; i < n_meas; i++)
        begin
            if (noise)
            begin
                c = 1'($urandom_range(1));
                f = 1'($urandom_range(1));
            end
            else
            begin
                c = CMD_MEASURE;
                f = (i == 0) ? 1'b1 : ($urandom_range(19) == 0);
            end
            send_beat(c, f, pick_depth(base, spread));
        end
        for (int i = 0; i < n_cls; i++)
            send_beat(CMD_CLASSIFY, ($urandom_range(7) == 0), pick_depth(base, spread));
    endtask

    initial
    begin
        int frames;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // empty range straight out of reset
        send_beat(CMD_CLASSIFY, 1'b0, 16'd0);
        send_beat(CMD_CLASSIFY, 1'b0, 16'd1);
        send_beat(CMD_CLASSIFY, 1'b0, 16'hFFFF);
        // range 1000..5000, zero ignored while measuring
        send_beat(CMD_MEASURE, 1'b1, 16'd1000);
        send_beat(CMD_MEASURE, 1'b0, 16'd0);
        send_beat(CMD_MEASURE, 1'b0, 16'd5000);
        send_beat(CMD_CLASSIFY, 1'b0, 16'd0);
        send_beat(CMD_CLASSIFY, 1'b0, 16'd999);
        send_beat(CMD_CLASSIFY, 1'b0, 16'd1000);
        send_beat(CMD_CLASSIFY, 1'b0, 16'd1999);
        send_beat(CMD_CLASSIFY, 1'b0, 16'd2000);
        send_beat(CMD_CLASSIFY, 1'b0, 16'd3000);
        send_beat(CMD_CLASSIFY, 1'b1, 16'd4999);
        send_beat(CMD_CLASSIFY, 1'b0, 16'd5000);
        send_beat(CMD_CLASSIFY, 1'b0, 16'hFFFF);
        // single sample: empty range
        send_beat(CMD_MEASURE, 1'b1, 16'hFFFF);
        send_beat(CMD_CLASSIFY, 1'b0, 16'hFFFF);
        // widest range
        send_beat(CMD_MEASURE, 1'b1, 16'd1);
        send_beat(CMD_MEASURE, 1'b0, 16'hFFFF);
        send_beat(CMD_CLASSIFY, 1'b0, 16'd1);
        send_beat(CMD_CLASSIFY, 1'b0, 16'd16384);
        send_beat(CMD_CLASSIFY, 1'b0, 16'd16385);
        send_beat(CMD_CLASSIFY, 1'b0, 16'hFFFE);
        // restart with no reading
        send_beat(CMD_MEASURE, 1'b1, 16'd0);
        send_beat(CMD_CLASSIFY, 1'b0, 16'd7);

        frames = 0;
        while (items < RANDOM_ITEMS)
        begin
            run_frame();
            frames++;
            if (frames % 30 == 15)
            begin
                in_valid <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
